// ===== src/sbem_pkg.sv =====
package sbem_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int POS_W      = 32;
    localparam int MIN_W      = 20;
    localparam int LEN_W      = 21;
    localparam int OFS_W      = 20;
    localparam int RES_W      = LEN_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;

    localparam logic [MIN_W-1:0] MIN_BLOCK_RESET = MIN_W'(131072);
    localparam logic [LEN_W-1:0] MAX_BLOCK_RESET = LEN_W'(262144);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_OUT_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_LOCATE = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_BLOCK = 1'b0,
        REG_MAX_BLOCK = 1'b1
    } cfg_index_t;

endpackage

// ===== src/sbem_channels.sv =====
interface sbem_req_if;
    import sbem_pkg::*;
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [POS_W-1:0] request_length;
    logic [POS_W-1:0] position;
    modport source (output valid, opcode, request_length, position, input ready);
    modport sink (input valid, opcode, request_length, position, output ready);
endinterface

interface sbem_rsp_if;
    import sbem_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [IDX_W-1:0] block_index;
    logic [POS_W-1:0] block_first_sample;
    logic [OFS_W-1:0] offset_in_block;
    logic [LEN_W-1:0] best_chunk_length;
    logic [LEN_W-1:0] ideal_append_length;
    logic [CNT_W-1:0] blocks_in_use;
    logic [POS_W-1:0] sample_total;
    modport source (output valid, status, block_index, block_first_sample, offset_in_block,
                    best_chunk_length, ideal_append_length, blocks_in_use, sample_total,
                    input ready);
    modport sink (input valid, status, block_index, block_first_sample, offset_in_block,
                  best_chunk_length, ideal_append_length, blocks_in_use, sample_total,
                  output ready);
endinterface

interface sbem_cfg_if;
    import sbem_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/sample_block_extent_map_top.sv =====
// Append checks for overflow and for room, then writes the new blocks one after another;
// locate checks the range, runs a binary search over the block starts and then merges
// following blocks into the chunk. Empty, overflowing, full or out-of-range items end early.
// Throughput: one item at a time; a finished item waits while the output register is held.
// Reset clears block count, total, configuration and handshake state at once; the
// table itself is not cleared, as only entries below the block count are ever read.
module sample_block_extent_map_top (
    input  logic       clk,
    input  logic       rst_n,
    sbem_req_if.sink   req,
    sbem_rsp_if.source rsp,
    sbem_cfg_if.sink   cfg
);
    import sbem_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_APP_A, S_APP_B, S_APP_FILL,
        S_LOC_A, S_LOC_S, S_LOC_W, S_LOC_R, S_LOC_X, S_LOC_XW, S_DONE
    } state_t;

    // Block table: start and length share one address per cycle for reads and
    // one for writes; read data is registered.
    logic [POS_W-1:0] start_mem [MAX_BLOCKS];
    logic [LEN_W-1:0] len_mem   [MAX_BLOCKS];
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             wr_start_en, wr_len_en;
    logic [POS_W-1:0] wr_start;
    logic [LEN_W-1:0] wr_len;
    logic [POS_W-1:0] rd_start_reg;
    logic [LEN_W-1:0] rd_len_reg;

    always_ff @(posedge clk)
    begin
        if (wr_start_en)
        begin
            start_mem[wr_addr] <= wr_start;
        end
        if (wr_len_en)
        begin
            len_mem[wr_addr] <= wr_len;
        end
        rd_start_reg <= start_mem[rd_addr];
        rd_len_reg   <= len_mem[rd_addr];
    end

    state_t           state_reg;
    logic [MIN_W-1:0] min_reg;
    logic [LEN_W-1:0] max_reg;
    logic [CNT_W-1:0] count_reg;
    logic [POS_W-1:0] total_reg;
    logic [LEN_W-1:0] last_len_reg;   // copy of the last block's length
    logic [POS_W-1:0] arg_reg;        // request length or position
    logic [POS_W-1:0] rem_reg;
    logic [POS_W-1:0] prod_reg;
    logic [LEN_W-1:0] add_reg;
    logic [POS_W-1:0] next_reg;
    logic [CNT_W-1:0] lo_reg, hi_reg, mid_reg, b_reg;
    logic [RES_W-1:0] res_reg;
    status_t          st_reg;
    logic [IDX_W-1:0] bidx_reg;
    logic [POS_W-1:0] bfirst_reg;
    logic [OFS_W-1:0] offs_reg;

    logic             out_valid_reg;
    logic [1:0]       o_status_reg;
    logic [IDX_W-1:0] o_bidx_reg;
    logic [POS_W-1:0] o_bfirst_reg;
    logic [OFS_W-1:0] o_offs_reg;
    logic [LEN_W-1:0] o_best_reg;
    logic [LEN_W-1:0] o_ideal_reg;
    logic [CNT_W-1:0] o_count_reg;
    logic [POS_W-1:0] o_total_reg;

    // Combinational helpers.
    logic [LEN_W-1:0] mx;
    logic [LEN_W-1:0] room;
    logic [POS_W-1:0] add_full;
    logic             enlarge;
    logic [CNT_W-1:0] free_blocks;
    logic [POS_W:0]   total_sum;
    logic [CNT_W-1:0] mid;
    logic [LEN_W-1:0] piece;
    logic [POS_W:0]   res_full;
    logic [RES_W:0]   ext_sum;
    logic [LEN_W-1:0] ideal;

    always_comb
    begin
        mx          = (max_reg == '0) ? LEN_W'(1) : max_reg;
        enlarge     = (count_reg != '0) && (last_len_reg < LEN_W'(min_reg));
        room        = (mx > last_len_reg) ? (mx - last_len_reg) : '0;
        add_full    = enlarge ? ((POS_W'(room) < arg_reg) ? POS_W'(room) : arg_reg) : '0;
        free_blocks = CNT_W'(MAX_BLOCKS) - count_reg;
        total_sum   = {1'b0, total_reg} + {1'b0, arg_reg};
        mid         = lo_reg + ((hi_reg - lo_reg) >> 1);
        piece       = (rem_reg < POS_W'(mx)) ? rem_reg[LEN_W-1:0] : mx;
        res_full    = {1'b0, rd_start_reg} + (POS_W+1)'(rd_len_reg) - {1'b0, arg_reg};
        ext_sum     = (RES_W+1)'(rd_len_reg) + (RES_W+1)'(res_reg);
        if (count_reg == '0 || last_len_reg >= max_reg)
        begin
            ideal = max_reg;
        end
        else
        begin
            ideal = max_reg - last_len_reg;
        end
    end

    // Memory port control follows the current state.
    always_comb
    begin
        rd_addr     = lo_reg[IDX_W-1:0];
        wr_addr     = count_reg[IDX_W-1:0];
        wr_start_en = 1'b0;
        wr_len_en   = 1'b0;
        wr_start    = next_reg;
        wr_len      = piece;
        case (state_reg)
            S_LOC_S:
            begin
                rd_addr = (hi_reg - lo_reg > CNT_W'(1)) ? mid[IDX_W-1:0] : lo_reg[IDX_W-1:0];
            end
            S_LOC_X:
            begin
                rd_addr = IDX_W'(b_reg + CNT_W'(1));
            end
            S_APP_B:
            begin
                if (rem_reg <= prod_reg && enlarge)
                begin
                    wr_addr   = IDX_W'(count_reg - CNT_W'(1));
                    wr_len_en = 1'b1;
                    wr_len    = last_len_reg + add_reg;
                end
            end
            S_APP_FILL:
            begin
                if (rem_reg != '0)
                begin
                    wr_start_en = 1'b1;
                    wr_len_en   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid               = out_valid_reg;
    assign rsp.status              = o_status_reg;
    assign rsp.block_index         = o_bidx_reg;
    assign rsp.block_first_sample  = o_bfirst_reg;
    assign rsp.offset_in_block     = o_offs_reg;
    assign rsp.best_chunk_length   = o_best_reg;
    assign rsp.ideal_append_length = o_ideal_reg;
    assign rsp.blocks_in_use       = o_count_reg;
    assign rsp.sample_total        = o_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_reg       <= MIN_BLOCK_RESET;
            max_reg       <= MAX_BLOCK_RESET;
            count_reg     <= '0;
            total_reg     <= '0;
            last_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_index_t'(cfg.index))
                    REG_MIN_BLOCK: min_reg <= cfg.data[MIN_W-1:0];
                    REG_MAX_BLOCK: max_reg <= cfg.data[LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            // In the finishing state the output register is handled below.
            if (rsp.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        st_reg     <= ST_OK;
                        bidx_reg   <= '0;
                        bfirst_reg <= '0;
                        offs_reg   <= '0;
                        res_reg    <= '0;
                        if (opcode_t'(req.opcode) == OP_APPEND)
                        begin
                            arg_reg   <= req.request_length;
                            state_reg <= S_APP_A;
                        end
                        else
                        begin
                            arg_reg   <= req.position;
                            state_reg <= S_LOC_A;
                        end
                    end
                end

                // Append: overflow test, room check, fill of the last block.
                S_APP_A:
                begin
                    if (arg_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (total_sum[POS_W])
                    begin
                        st_reg    <= ST_OVERFLOW;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        add_reg   <= add_full[LEN_W-1:0];
                        rem_reg   <= arg_reg - add_full;
                        prod_reg  <= POS_W'(free_blocks) * POS_W'(mx);
                        state_reg <= S_APP_B;
                    end
                end

                S_APP_B:
                begin
                    if (rem_reg > prod_reg)
                    begin
                        st_reg    <= ST_FULL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (enlarge)
                        begin
                            last_len_reg <= last_len_reg + add_reg;
                        end
                        next_reg  <= total_reg + POS_W'(add_reg);
                        total_reg <= total_sum[POS_W-1:0];
                        state_reg <= S_APP_FILL;
                    end
                end

                // One new block is written each cycle.
                S_APP_FILL:
                begin
                    if (rem_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        count_reg    <= count_reg + CNT_W'(1);
                        last_len_reg <= piece;
                        next_reg     <= next_reg + POS_W'(piece);
                        rem_reg      <= rem_reg - POS_W'(piece);
                    end
                end

                S_LOC_A:
                begin
                    if (arg_reg >= total_reg || count_reg == '0)
                    begin
                        st_reg    <= ST_OUT_RANGE;
                        res_reg   <= RES_W'(max_reg);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= count_reg;
                        state_reg <= S_LOC_S;
                    end
                end

                // Binary search: one table read per halving.
                S_LOC_S:
                begin
                    mid_reg <= mid;
                    if (hi_reg - lo_reg > CNT_W'(1))
                    begin
                        state_reg <= S_LOC_W;
                    end
                    else
                    begin
                        state_reg <= S_LOC_R;
                    end
                end

                S_LOC_W:
                begin
                    if (rd_start_reg <= arg_reg)
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= S_LOC_S;
                end

                S_LOC_R:
                begin
                    bidx_reg   <= lo_reg[IDX_W-1:0];
                    bfirst_reg <= rd_start_reg;
                    offs_reg   <= OFS_W'(arg_reg - rd_start_reg);
                    res_reg    <= res_full[RES_W-1:0];
                    b_reg      <= lo_reg;
                    state_reg  <= S_LOC_X;
                end

                // Extend the chunk over following blocks while it is short and stays within the block size.
                S_LOC_X:
                begin
                    if (res_reg < RES_W'(min_reg) && (b_reg + CNT_W'(1)) < count_reg)
                    begin
                        state_reg <= S_LOC_XW;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_LOC_XW:
                begin
                    if (ext_sum > (RES_W+1)'(max_reg))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        b_reg     <= b_reg + CNT_W'(1);
                        res_reg   <= ext_sum[RES_W-1:0];
                        state_reg <= S_LOC_X;
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        o_status_reg  <= st_reg;
                        o_bidx_reg    <= bidx_reg;
                        o_bfirst_reg  <= bfirst_reg;
                        o_offs_reg    <= offs_reg;
                        o_best_reg    <= res_reg[LEN_W-1:0];
                        o_ideal_reg   <= ideal;
                        o_count_reg   <= count_reg;
                        o_total_reg   <= total_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    import sbem_pkg::*;

    // One result item as the block reports it.
    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] block_index;
        logic [POS_W-1:0] block_first_sample;
        logic [OFS_W-1:0] offset_in_block;
        logic [LEN_W-1:0] best_chunk_length;
        logic [LEN_W-1:0] ideal_append_length;
        logic [CNT_W-1:0] blocks_in_use;
        logic [POS_W-1:0] sample_total;
    } extent_result_t;

    // One row of the directed table. Where known_result is set, the expected
    // result is typed in and replaces what the predictor works out.
    typedef struct {
        opcode_t        op;
        logic [31:0]    length;
        logic [31:0]    pos;
        bit             known_result;
        extent_result_t result;
    } directed_row_t;

    localparam int STALL_PCT   = 33;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 20000;

    logic clk;
    logic rst_n;

    sbem_req_if req_ch ();
    sbem_rsp_if rsp_ch ();
    sbem_cfg_if cfg_ch ();

    sample_block_extent_map_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // Shadow copy of the extent table and its settings.
    int unsigned shadow_start [MAX_BLOCKS];
    int unsigned shadow_len [MAX_BLOCKS];
    int unsigned shadow_count;
    int unsigned shadow_total;
    int unsigned shadow_min;
    int unsigned shadow_max;

    extent_result_t pending_results [$];
    int             error_count;
    bit             gaps_on;
    bit             hold_request;
    int             idle_cycles;

    directed_row_t directed_rows [$];

    // Clock and the single reset at the start of the run.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Room left in the last block, or the full block size where there is none.
    function automatic int unsigned room_in_last();
        int unsigned last;
        if (shadow_count == 0)
        begin
            return shadow_max;
        end
        last = shadow_len[shadow_count - 1];
        if (last >= shadow_max)
        begin
            return shadow_max;
        end
        return shadow_max - last;
    endfunction

    // Appends a run of samples to the shadow table and gives the status.
    function automatic status_t append_samples(int unsigned length);
        longint unsigned block_size;
        longint unsigned left;
        longint unsigned room;
        longint unsigned grow;
        longint unsigned new_blocks;
        int unsigned     last;
        int unsigned     next_start;
        block_size = (shadow_max != 0) ? shadow_max : 1;
        left = length;
        grow = 0;
        if (length == 0)
        begin
            return ST_OK;
        end
        if (longint'(shadow_total) + length > 64'hFFFF_FFFF)
        begin
            return ST_OVERFLOW;
        end
        // A short last block is topped up first.
        if (shadow_count > 0)
        begin
            last = shadow_len[shadow_count - 1];
            if (last < shadow_min)
            begin
                room = (block_size > last) ? block_size - last : 0;
                grow = (room < left) ? room : left;
                left -= grow;
            end
        end
        new_blocks = (left + block_size - 1) / block_size;
        if (shadow_count + new_blocks > MAX_BLOCKS)
        begin
            return ST_FULL;
        end
        if (shadow_count > 0 && shadow_len[shadow_count - 1] < shadow_min)
        begin
            shadow_len[shadow_count - 1] += int'(grow);
        end
        next_start = shadow_total + int'(grow);
        for (longint unsigned n = 0; n < new_blocks; n++)
        begin
            shadow_start[shadow_count] = next_start;
            shadow_len[shadow_count] = (left < block_size) ? int'(left) : int'(block_size);
            next_start += shadow_len[shadow_count];
            left -= shadow_len[shadow_count];
            shadow_count++;
        end
        shadow_total += length;
        return ST_OK;
    endfunction

    // Works out the result of one item and updates the shadow table.
    function automatic extent_result_t predict_extent(opcode_t op, logic [31:0] length,
                                                      logic [31:0] pos);
        extent_result_t  r;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        int unsigned     b;
        longint unsigned chunk;
        r = '0;
        if (op == OP_APPEND)
        begin
            r.status = append_samples(length);
        end
        else if (pos >= shadow_total || shadow_count == 0)
        begin
            r.status = ST_OUT_RANGE;
            r.best_chunk_length = LEN_W'(shadow_max);
        end
        else
        begin
            lo = 0;
            hi = shadow_count;
            while (hi - lo > 1)
            begin
                mid = lo + (hi - lo) / 2;
                if (shadow_start[mid] <= pos)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid;
                end
            end
            b = lo;
            chunk = longint'(shadow_start[b]) + shadow_len[b] - pos;
            r.status = ST_OK;
            r.block_index = IDX_W'(b);
            r.block_first_sample = shadow_start[b];
            r.offset_in_block = OFS_W'(pos - shadow_start[b]);
            // The chunk runs on over whole blocks while it is still short.
            while (chunk < shadow_min && b + 1 < shadow_count)
            begin
                if (longint'(shadow_len[b + 1]) + chunk > shadow_max)
                begin
                    break;
                end
                b++;
                chunk += shadow_len[b];
            end
            r.best_chunk_length = LEN_W'(chunk);
        end
        r.ideal_append_length = LEN_W'(room_in_last());
        r.blocks_in_use = CNT_W'(shadow_count);
        r.sample_total = shadow_total;
        return r;
    endfunction

    function automatic extent_result_t known(status_t st, int unsigned best, int unsigned ideal,
                                             int unsigned count, int unsigned total);
        extent_result_t r;
        r = '0;
        r.status = st;
        r.best_chunk_length = LEN_W'(best);
        r.ideal_append_length = LEN_W'(ideal);
        r.blocks_in_use = CNT_W'(count);
        r.sample_total = total;
        return r;
    endfunction

    function automatic void add_row(opcode_t op, logic [31:0] length, logic [31:0] pos,
                                    bit has_result, extent_result_t r);
        directed_row_t row;
        row.op = op;
        row.length = length;
        row.pos = pos;
        row.known_result = has_result;
        row.result = r;
        directed_rows = {directed_rows, row};
    endfunction

    // Offers one item, idling beforehand at random, and records its expected
    // result once the block has taken it. Valid stays high for the next item.
    task automatic send_item(opcode_t op, logic [31:0] length, logic [31:0] pos,
                             bit has_result, extent_result_t typed);
        extent_result_t r;
        if (gaps_on && $urandom_range(99, 0) < STALL_PCT)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.request_length <= length;
        req_ch.position <= pos;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        r = predict_extent(op, length, pos);
        if (has_result)
        begin
            r = typed;
        end
        pending_results = {pending_results, r};
    endtask

    // Waits until every expected result has come, with a short margin after.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t index, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        if (index == REG_MIN_BLOCK)
        begin
            shadow_min = value[MIN_W-1:0];
        end
        else
        begin
            shadow_max = value;
        end
    endtask

    // One phase of random items. Appends are mostly small against the block
    // size, so the table fills slowly; a few are large, and the huge ones are
    // often rejected as full or overflowing. Locates mostly land inside the map.
    task automatic random_phase(int items, int unsigned append_scale);
        opcode_t     op;
        logic [31:0] length;
        logic [31:0] pos;
        int unsigned pick;
        int unsigned block_size;
        for (int n = 0; n < items; n++)
        begin
            block_size = (shadow_max != 0) ? shadow_max : 1;
            op = ($urandom_range(99, 0) < 55) ? OP_LOCATE : OP_APPEND;
            pick = $urandom_range(99, 0);
            length = $urandom;
            pos = $urandom;
            if (op == OP_APPEND)
            begin
                if (pick < 75)
                begin
                    length = $urandom_range(append_scale, 0);
                end
                else if (pick < 88)
                begin
                    length = $urandom_range(3 * block_size, 0);
                end
            end
            else if (pick < 82 && shadow_total > 0)
            begin
                pos = $urandom_range(shadow_total - 1, 0);
            end
            else if (pick < 92)
            begin
                pos = shadow_total + $urandom_range(3, 0);
            end
            send_item(op, length, pos, 1'b0, '0);
        end
    endtask

    // Result side: checks every result item against the oldest expectation
    // and sets ready for the next edge, with random stalls and one long hold.
    initial
    begin
        int             hold_left;
        extent_result_t want;
        extent_result_t got;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = status_t'(rsp_ch.status);
                got.block_index = rsp_ch.block_index;
                got.block_first_sample = rsp_ch.block_first_sample;
                got.offset_in_block = rsp_ch.offset_in_block;
                got.best_chunk_length = rsp_ch.best_chunk_length;
                got.ideal_append_length = rsp_ch.ideal_append_length;
                got.blocks_in_use = rsp_ch.blocks_in_use;
                got.sample_total = rsp_ch.sample_total;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result item with none expected: %p", $time, got);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        error_count++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= !(gaps_on && $urandom_range(99, 0) < STALL_PCT);
            end
        end
    end

    // Watchdog: ends the run when no channel has moved an item for too long.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL sample_block_extent_map_top");
                $finish;
            end
        end
    end

    // Stimulus: directed table first, then phases of random items under a
    // range of block sizes, the extremes among them.
    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.opcode <= OP_APPEND;
        req_ch.request_length <= '0;
        req_ch.position <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_MIN_BLOCK;
        cfg_ch.data <= '0;
        error_count = 0;
        gaps_on = 1'b1;
        hold_request = 1'b0;
        shadow_count = 0;
        shadow_total = 0;
        shadow_min = MIN_BLOCK_RESET;
        shadow_max = MAX_BLOCK_RESET;

        // Empty map: everything is out of range and the huge append cannot fit.
        add_row(OP_LOCATE, 0, 0, 1, known(ST_OUT_RANGE, 262144, 262144, 0, 0));
        add_row(OP_APPEND, 0, 0, 1, known(ST_OK, 0, 262144, 0, 0));
        add_row(OP_APPEND, 32'hFFFF_FFFF, 0, 1, known(ST_FULL, 0, 262144, 0, 0));
        add_row(OP_LOCATE, 0, 32'hFFFF_FFFF, 1, known(ST_OUT_RANGE, 262144, 262144, 0, 0));
        add_row(OP_APPEND, 100, 0, 0, '0);
        add_row(OP_LOCATE, 0, 0, 0, '0);
        add_row(OP_LOCATE, 0, 99, 0, '0);
        // Position exactly at the end of the map.
        add_row(OP_LOCATE, 0, 100, 1, known(ST_OUT_RANGE, 262144, 262044, 1, 100));
        // A total that would pass 32 bits is rejected ahead of the table check.
        add_row(OP_APPEND, 32'hFFFF_FFFF, 0, 1, known(ST_OVERFLOW, 0, 262044, 1, 100));
        add_row(OP_APPEND, 600000, 0, 0, '0);
        add_row(OP_LOCATE, 0, 262143, 0, '0);
        add_row(OP_LOCATE, 0, 262144, 0, '0);
        add_row(OP_LOCATE, 0, 600099, 0, '0);
        add_row(OP_APPEND, 1, 0, 0, '0);
        add_row(OP_LOCATE, 0, 524288, 0, '0);
        add_row(OP_APPEND, 32'hFFFF_FFFF - 600101, 0, 0, '0);
        add_row(OP_APPEND, 32'hFFFF_FFFF - 600100, 0, 0, '0);
        add_row(OP_LOCATE, 0, 600100, 0, '0);

        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].op, directed_rows[i].length, directed_rows[i].pos,
                      directed_rows[i].known_result, directed_rows[i].result);
        end
        drain();

        // Large sizes: appends mostly top up the last block.
        write_register(REG_MIN_BLOCK, 21'd524288);
        write_register(REG_MAX_BLOCK, 21'd1048576);
        random_phase(150, 131072);
        hold_request = 1'b1;
        random_phase(150, 131072);
        drain();

        // Tiny blocks of two samples each.
        write_register(REG_MIN_BLOCK, 21'd1);
        write_register(REG_MAX_BLOCK, 21'd2);
        random_phase(150, 6);
        drain();

        // All-ones settings, so locates merge runs of the tiny blocks; no idling.
        gaps_on = 1'b0;
        write_register(REG_MIN_BLOCK, 21'h1F_FFFF);
        write_register(REG_MAX_BLOCK, 21'h1F_FFFF);
        random_phase(250, 65536);
        drain();
        gaps_on = 1'b1;

        // Zero block size: new blocks hold one sample each.
        write_register(REG_MIN_BLOCK, 21'd1000);
        write_register(REG_MAX_BLOCK, 21'd0);
        random_phase(100, 3);
        drain();

        // Random settings; in the second pass the sender also drains between its two phases.
        for (int p = 0; p < 3; p++)
        begin
            write_register(REG_MIN_BLOCK, CFG_DATA_W'($urandom_range(32'h1F_FFFF, 1)));
            write_register(REG_MAX_BLOCK, CFG_DATA_W'($urandom_range(4096, 2)));
            random_phase(100, shadow_max / 4 + 1);
            if (p == 1)
            begin
                drain();
            end
            random_phase(100, shadow_max / 4 + 1);
            drain();
        end

        // Block size below the short-block limit: the last block is topped up to the block size.
        write_register(REG_MIN_BLOCK, 21'd5000);
        write_register(REG_MAX_BLOCK, 21'd3000);
        random_phase(200, 1500);
        drain();

        // Small blocks and long appends fill the table to the end.
        write_register(REG_MIN_BLOCK, 21'd1);
        write_register(REG_MAX_BLOCK, 21'd64);
        random_phase(250, 512);
        drain();

        if (error_count == 0)
        begin
            $display("PASS sample_block_extent_map_top");
        end
        else
        begin
            $display("FAIL sample_block_extent_map_top");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sbem_pkg.sv
src/sbem_channels.sv
src/sample_block_extent_map_top.sv
dv/tb.sv
